// ----- design/i2cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, queue item and result types, and the phase count of each
// command, shared by the front, queue and back of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbe_pkg;

    // Bus command codes as they arrive in the mode field
    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_STOP    = 3'd1,
        CMD_TX_BYTE = 3'd2,
        CMD_RX_BYTE = 3'd3,
        CMD_TX_ACK  = 3'd4,
        CMD_RX_ACK  = 3'd5
    } t_cmd;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd720;

    // One classified tick as it waits in the queue
    typedef struct packed {
        logic       start_req;  // a legal command is offered on this tick
        t_cmd       cmd;
        logic [7:0] shift_init; // byte to send, or the ack level in bit 0
        logic       sda_in;
    } t_item;

    // What the engine reports for one tick
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_result;

    // Number of pin phases in each command
    function automatic logic [4:0] seq_len(input t_cmd cmd);
        logic [4:0] len;
        case (cmd)
            CMD_START:   len = 5'd4;
            CMD_STOP:    len = 5'd3;
            CMD_TX_BYTE: len = 5'd24;
            CMD_RX_BYTE: len = 5'd17;
            CMD_TX_ACK:  len = 5'd3;
            default:     len = 5'd3;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- design/i2cbe_front.sv -----
// ----------------------------------------------------------------------------
// I2C bit engine front end
// Classifies each incoming tick: decides whether it offers a legal command
// and prepares the shift register load for it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbe_front
    import i2cbe_pkg::*;
(
    input  wire logic       i_cmd_valid,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic       i_ack_level,
    input  wire logic       i_sda_in,
    output t_item           o_item
);

    always_comb begin
        o_item.start_req = i_cmd_valid && (i_mode <= CMD_RX_ACK);
        o_item.cmd       = o_item.start_req ? t_cmd'(i_mode) : CMD_START;
        o_item.sda_in    = i_sda_in;
        case (i_mode)
            CMD_TX_BYTE: o_item.shift_init = i_tx_byte;
            CMD_TX_ACK:  o_item.shift_init = {7'd0, i_ack_level};
            default:     o_item.shift_init = 8'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/i2cbe_queue.sv -----
// ----------------------------------------------------------------------------
// I2C bit engine item queue
// Small first-in first-out queue of classified ticks between the front end
// and the bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbe_queue
    import i2cbe_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_item      i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_item      o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic            push_ok;
    logic            pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/i2cbe_back.sv -----
// ----------------------------------------------------------------------------
// I2C bit engine sequencer
// Runs the pin phases of the current command one tick at a time and holds
// the result of each tick in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbe_back
    import i2cbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  t_item            i_item,
    input  wire logic        i_item_valid,
    output logic             o_pop,
    output t_result          o_result,
    output logic             o_valid,
    input  wire logic        i_ready
);

    logic [15:0] r_ticks;
    t_cmd        r_cmd,     n_cmd;
    logic [4:0]  r_idx,     n_idx;
    logic [1:0]  r_sub,     n_sub;
    logic [2:0]  r_bit,     n_bit;
    logic [15:0] r_hold,    n_hold;
    logic [7:0]  r_shift,   n_shift;
    logic        r_scl,     n_scl;
    logic        r_sda,     n_sda;
    logic        r_running, n_running;
    logic        r_ack,     n_ack;
    logic [7:0]  r_rx_last, n_rx_last;
    logic        r_out_valid, n_out_valid;
    t_result     r_result,  n_result;

    assign o_pop    = i_item_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    always_comb begin
        logic        start;
        logic        run;
        t_cmd        cmd;
        logic [4:0]  idx;
        logic [1:0]  sub;
        logic [2:0]  bitn;
        logic [15:0] hold;
        logic [7:0]  shift;
        logic [15:0] ticks;
        logic        pin_sda;
        logic        level;
        logic        sample;
        logic [15:0] hold_inc;
        logic [4:0]  idx_inc;
        logic        busy;
        logic        done;

        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_sub       = r_sub;
        n_bit       = r_bit;
        n_hold      = r_hold;
        n_shift     = r_shift;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_running   = r_running;
        n_ack       = r_ack;
        n_rx_last   = r_rx_last;
        n_out_valid = r_out_valid && !i_ready;
        n_result    = r_result;

        ticks = (r_ticks == 16'd0) ? 16'd1 : r_ticks;
        start = !r_running && i_item.start_req;
        run   = r_running || start;
        cmd   = start ? i_item.cmd        : r_cmd;
        idx   = start ? 5'd0              : r_idx;
        sub   = start ? 2'd0              : r_sub;
        bitn  = start ? 3'd0              : r_bit;
        hold  = start ? 16'd0             : r_hold;
        shift = start ? i_item.shift_init : r_shift;

        // Pin, level and sampling of the phase in hand
        sample = 1'b0;
        case (cmd)
            CMD_START: begin
                pin_sda = (idx == 5'd0) || (idx == 5'd2);
                level   = (idx < 5'd2);
            end
            CMD_STOP: begin
                pin_sda = (idx != 5'd1);
                level   = (idx != 5'd0);
            end
            CMD_TX_BYTE: begin
                pin_sda = (sub == 2'd0);
                level   = (sub == 2'd0) ? shift[3'd7 - bitn] : (sub == 2'd1);
            end
            CMD_RX_BYTE: begin
                pin_sda = (idx == 5'd0);
                level   = (idx == 5'd0) ? 1'b1 : idx[0];
                sample  = (idx != 5'd0) && idx[0];
            end
            CMD_TX_ACK: begin
                pin_sda = (idx == 5'd0);
                level   = (idx == 5'd0) ? shift[0] : (idx == 5'd1);
            end
            default: begin
                pin_sda = (idx == 5'd0);
                level   = (idx != 5'd2);
                sample  = (idx == 5'd1);
            end
        endcase

        hold_inc = hold + 16'd1;
        idx_inc  = idx + 5'd1;
        busy     = 1'b0;
        done     = 1'b0;

        if (o_pop) begin
            n_out_valid = 1'b1;
            n_cmd       = cmd;
            n_idx       = idx;
            n_sub       = sub;
            n_bit       = bitn;
            n_hold      = hold;
            n_shift     = shift;
            n_running   = run;
            if (run) begin
                busy = 1'b1;
                // A pin only changes on the first tick of its phase
                if (hold == 16'd0) begin
                    if (pin_sda) begin
                        n_sda = level;
                    end else begin
                        n_scl = level;
                    end
                end
                n_hold = hold_inc;
                if (hold_inc >= ticks) begin
                    if (sample) begin
                        if (cmd == CMD_RX_BYTE) begin
                            n_shift = {shift[6:0], i_item.sda_in};
                        end else begin
                            n_ack = i_item.sda_in;
                        end
                    end
                    n_idx  = idx_inc;
                    n_hold = 16'd0;
                    n_sub  = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
                    n_bit  = (sub == 2'd2) ? bitn + 3'd1 : bitn;
                    if (idx_inc >= seq_len(cmd)) begin
                        if (cmd == CMD_RX_BYTE) begin
                            n_rx_last = n_shift;
                        end
                        n_running = 1'b0;
                        n_idx     = 5'd0;
                        done      = 1'b1;
                    end
                end
            end
            n_result.scl_out  = n_scl;
            n_result.sda_out  = n_sda;
            n_result.busy_res = busy;
            n_result.done_res = done;
            n_result.rx_byte  = n_rx_last;
            n_result.ack_seen = n_ack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= PHASE_TICKS_RESET;
            r_cmd       <= CMD_START;
            r_idx       <= 5'd0;
            r_sub       <= 2'd0;
            r_bit       <= 3'd0;
            r_hold      <= 16'd0;
            r_shift     <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_running   <= 1'b0;
            r_ack       <= 1'b1;
            r_rx_last   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ticks <= i_cfg_wdata;
            end
            r_cmd       <= n_cmd;
            r_idx       <= n_idx;
            r_sub       <= n_sub;
            r_bit       <= n_bit;
            r_hold      <= n_hold;
            r_shift     <= n_shift;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_running   <= n_running;
            r_ack       <= n_ack;
            r_rx_last   <= n_rx_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

endmodule

`default_nettype wire

// ----- design/i2c_master_bit_engine.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine
// Turns start, stop, byte and ack commands into timed SCL and SDA levels.
// ----------------------------------------------------------------------------
// Each word on the slave stream is one tick of the bus timer. It carries an
// optional command in tuser and the byte or ack level to send together with
// the sampled SDA line in tdata. For every accepted word exactly one word
// leaves on the master stream, holding the SCL and SDA drive after that tick,
// the busy and done flags, the last received byte and the last ack seen.
// A command that arrives while a sequence runs, or that has an unused code,
// is dropped without effect.
// Each pin change is held for phase_ticks ticks, written through i_cfg_we and
// i_cfg_wdata; the user writes it only while no word is in flight (the block
// does not enforce this). Zero behaves as one; a lower value ends a phase
// already held that long. A word is classified on entry and parked in a
// two-entry queue; while the output register is empty or being taken, the
// sequencer takes one word per cycle from it into that register. A result
// passes the queue and then the output register before it is offered, and one
// word per cycle is sustained: the sequencer's phase update is the only loop.
// When the receiver stalls, the result waits in the output register and the
// queue absorbs up to two more words before tready falls.
// Synchronous reset releases both lines, clears the queue and the received
// byte, sets the ack seen to one and restores phase_ticks to 720.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine
    import i2cbe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: phase_ticks
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    // Tick input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata from bit 0: tx_byte[7:0], ack_level, sda_in, zero padding
    input  wire logic [15:0] s_axis_tdata,
    // tuser from bit 0: cmd_valid, mode[2:0]
    input  wire logic [3:0]  s_axis_tuser,
    // Result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata from bit 0: scl_out, sda_out, busy_res, done_res, rx_byte[7:0],
    // ack_seen, zero padding
    output logic [15:0]      m_axis_tdata
);

    t_item   item_in;
    t_item   item_out;
    t_result result;
    logic    queue_full;
    logic    queue_empty;
    logic    pop;

    assign s_axis_tready = !queue_full;

    // Decode the command and prepare the shift register load
    i2cbe_front u_front (
        .i_cmd_valid (s_axis_tuser[0]),
        .i_mode      (s_axis_tuser[3:1]),
        .i_tx_byte   (s_axis_tdata[7:0]),
        .i_ack_level (s_axis_tdata[8]),
        .i_sda_in    (s_axis_tdata[9]),
        .o_item      (item_in)
    );

    // Decouples input acceptance from output back-pressure
    i2cbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (item_in),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_data  (item_out)
    );

    // Phase sequencer and output register
    i2cbe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item       (item_out),
        .i_item_valid (!queue_empty),
        .o_pop        (pop),
        .o_result     (result),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready)
    );

    assign m_axis_tdata = {3'd0, result.ack_seen, result.rx_byte, result.done_res,
                           result.busy_res, result.sda_out, result.scl_out};

endmodule

`default_nettype wire

// ----- design/i2cbe_checker.sv -----
// ----------------------------------------------------------------------------
// I2C bit engine port checker
// Watches the stream ports of the engine over time.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // A stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // The end of a command is always reported on a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> m_axis_tdata[2])
        else $error("done without busy");

    // The queue only fills up behind a waiting result
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result offered straight after reset");

endmodule

bind i2c_master_bit_engine i2cbe_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/tb_i2c_master_bit_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the I2C master bit engine
// Drives timer ticks, with optional bus commands, into the slave stream. A
// predictor works out the SCL and SDA drive, the flags, the received byte
// and the ack seen for every tick, and the results from the master stream
// are checked against it in order. Both streams idle and stall at random.
// ----------------------------------------------------------------------------

module tb_i2c_master_bit_engine;
    import i2cbe_pkg::*;

    // Mode codes with no command behind them; the engine must drop them.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // SDA pattern selectors for the generator.
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    // One timer tick as the generator sees it.
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } t_tick;

    // A pending entry is either a tick word or a write of phase_ticks.
    typedef struct {
        bit          is_cfg;
        logic [15:0] cfg_value;
        t_tick       tick;
    } t_pending;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;
    logic [3:0]  s_axis_tuser  = 4'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    // The engine under test. Slave tdata from bit 0: tx_byte, ack_level,
    // sda_in; slave tuser from bit 0: cmd_valid, mode. Master tdata from
    // bit 0: scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen.
    i2c_master_bit_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor state. It starts in the reset state, since reset is only
    // applied once at the start of the run and no word is taken during it.
    // ------------------------------------------------------------------
    logic [15:0] hold_ticks    = PHASE_TICKS_RESET;
    t_cmd        eng_cmd       = CMD_START;
    logic [4:0]  eng_phase     = 5'd0;
    logic [15:0] eng_hold      = 16'd0;
    logic [7:0]  eng_shift     = 8'd0;
    logic        eng_scl       = 1'b1;
    logic        eng_sda       = 1'b1;
    logic        eng_running   = 1'b0;
    logic        eng_ack       = 1'b1;
    logic [7:0]  eng_rx_last   = 8'd0;

    t_result  expected_levels[$];
    t_pending pending_words[$];
    t_tick    cur_tick;
    bit       word_taken    = 1'b0;
    int       words_queued  = 0;
    int       words_taken   = 0;
    int       mismatches    = 0;
    int       gen_ticks     = int'(PHASE_TICKS_RESET);
    int       cmds_issued   = 0;
    bit       stimulus_done = 1'b0;
    int       burst_left    = 0;
    int       gap_left      = 0;
    int       stall_mode    = 0;
    int       cycle_count   = 0;

    // Advances the predicted engine by one tick and returns what the engine
    // should report for it.
    function automatic t_result step_engine(input t_tick w);
        t_result     r;
        logic [15:0] ticks;
        logic        on_scl;
        logic        level;
        logic        sample;
        logic [4:0]  sub;
        logic [2:0]  bit_no;
        logic [4:0]  phase_limit;

        ticks      = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
        r.busy_res = 1'b0;
        r.done_res = 1'b0;

        // A legal command is only taken while nothing is running.
        if (!eng_running && w.cmd_valid && w.mode <= CMD_RX_ACK) begin
            eng_cmd   = t_cmd'(w.mode);
            eng_phase = 5'd0;
            eng_hold  = 16'd0;
            case (eng_cmd)
                CMD_TX_BYTE: eng_shift = w.tx_byte;
                CMD_TX_ACK:  eng_shift = {7'd0, w.ack_level};
                default:     eng_shift = 8'd0;
            endcase
            eng_running = 1'b1;
        end

        if (eng_running) begin
            r.busy_res = 1'b1;
            sample     = 1'b0;
            on_scl     = 1'b1;
            level      = 1'b0;
            case (eng_cmd)
                CMD_START: begin
                    on_scl = !(eng_phase == 5'd0 || eng_phase == 5'd2);
                    level  = (eng_phase < 5'd2);
                end
                CMD_STOP: begin
                    on_scl = (eng_phase == 5'd1);
                    level  = (eng_phase != 5'd0);
                end
                CMD_TX_BYTE: begin
                    // Each bit is SDA set, SCL high, SCL low, MSB first.
                    sub    = eng_phase % 5'd3;
                    bit_no = 3'(eng_phase / 5'd3);
                    on_scl = (sub != 5'd0);
                    level  = (sub == 5'd0) ? eng_shift[3'd7 - bit_no] : (sub == 5'd1);
                end
                CMD_RX_BYTE: begin
                    // SDA is released first, then eight SCL pulses.
                    on_scl = (eng_phase != 5'd0);
                    level  = (eng_phase == 5'd0) ? 1'b1 : eng_phase[0];
                    sample = on_scl && level;
                end
                CMD_TX_ACK: begin
                    on_scl = (eng_phase != 5'd0);
                    level  = (eng_phase == 5'd0) ? eng_shift[0] : (eng_phase == 5'd1);
                end
                default: begin
                    on_scl = (eng_phase != 5'd0);
                    level  = (eng_phase != 5'd2);
                    sample = (eng_phase == 5'd1);
                end
            endcase

            // The pin changes on the first tick of its phase only.
            if (eng_hold == 16'd0) begin
                if (on_scl)
                    eng_scl = level;
                else
                    eng_sda = level;
            end
            eng_hold = eng_hold + 16'd1;

            // A phase ends once the hold reaches the current setting, which
            // may have been lowered while the phase was running.
            if (eng_hold >= ticks) begin
                if (sample) begin
                    if (eng_cmd == CMD_RX_BYTE)
                        eng_shift = {eng_shift[6:0], w.sda_in};
                    else
                        eng_ack = w.sda_in;
                end
                eng_phase = eng_phase + 5'd1;
                eng_hold  = 16'd0;
                case (eng_cmd)
                    CMD_START:   phase_limit = 5'd4;
                    CMD_TX_BYTE: phase_limit = 5'd24;
                    CMD_RX_BYTE: phase_limit = 5'd17;
                    default:     phase_limit = 5'd3;
                endcase
                if (eng_phase >= phase_limit) begin
                    if (eng_cmd == CMD_RX_BYTE)
                        eng_rx_last = eng_shift;
                    eng_running = 1'b0;
                    eng_phase   = 5'd0;
                    r.done_res  = 1'b1;
                end
            end
        end

        r.scl_out  = eng_scl;
        r.sda_out  = eng_sda;
        r.rx_byte  = eng_rx_last;
        r.ack_seen = eng_ack;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Generator helpers. They only fill the pending queue; the driver
    // below moves the words onto the bus.
    // ------------------------------------------------------------------
    task automatic push_tick(input logic cmd_valid, input logic [2:0] mode,
                             input logic [7:0] tx, input logic ack, input int sda_pat);
        t_pending p;
        p.is_cfg         = 1'b0;
        p.cfg_value      = 16'd0;
        p.tick.cmd_valid = cmd_valid;
        p.tick.mode      = mode;
        p.tick.tx_byte   = tx;
        p.tick.ack_level = ack;
        p.tick.sda_in    = (sda_pat == SDA_LOW)  ? 1'b0 :
                           (sda_pat == SDA_HIGH) ? 1'b1 : 1'($urandom_range(0, 1));
        pending_words.push_back(p);
        words_queued++;
    endtask

    // Plain timer ticks. With noisy set a few of them carry a command, which
    // the engine should drop because it is still busy.
    task automatic push_idle(input int n, input int sda_pat, input bit noisy);
        for (int i = 0; i < n; i++)
            push_tick(noisy && ($urandom_range(0, 15) == 0), 3'($urandom_range(0, 7)),
                      8'($urandom), 1'($urandom_range(0, 1)), sda_pat);
    endtask

    task automatic push_cfg(input logic [15:0] value);
        t_pending p;
        p.is_cfg    = 1'b1;
        p.cfg_value = value;
        p.tick      = '0;
        pending_words.push_back(p);
        gen_ticks = (value == 16'd0) ? 1 : int'(value);
    endtask

    // A command followed by enough ticks for it to finish. A broken command
    // is cut short so that the next one may land while the engine is busy.
    task automatic run_command(input logic [2:0] mode, input logic [7:0] tx,
                               input logic ack, input int sda_pat, input bit broken);
        int phases;
        int span;
        int idle;
        case (mode)
            CMD_START:   phases = 4;
            CMD_STOP:    phases = 3;
            CMD_TX_BYTE: phases = 24;
            CMD_RX_BYTE: phases = 17;
            CMD_TX_ACK:  phases = 3;
            CMD_RX_ACK:  phases = 3;
            default:     phases = 0;
        endcase
        span = (phases == 0) ? 1 : phases * gen_ticks;
        idle = broken ? $urandom_range(0, span - 1) : span - 1 + $urandom_range(0, 3);
        push_tick(1'b1, mode, tx, ack, sda_pat);
        if (span > 2 && idle > span - 2) begin
            push_idle(span - 2, sda_pat, $urandom_range(0, 3) == 0);
            push_idle(idle - (span - 2), sda_pat, 1'b0);
        end else begin
            push_idle(idle, sda_pat, 1'b0);
        end
        cmds_issued++;
    endtask

    // A well-formed bus transfer: start, a few bytes each with its ack, stop.
    task automatic run_transfer();
        int n_bytes;
        n_bytes = $urandom_range(1, 4);
        run_command(CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, 1'b0);
        repeat (n_bytes) begin
            if ($urandom_range(0, 1) == 0) begin
                run_command(CMD_TX_BYTE, 8'($urandom), 1'b0, SDA_RAND, 1'b0);
                run_command(CMD_RX_ACK, 8'($urandom), 1'b0, SDA_RAND, 1'b0);
            end else begin
                run_command(CMD_RX_BYTE, 8'($urandom), 1'b0, SDA_RAND, 1'b0);
                run_command(CMD_TX_ACK, 8'($urandom), 1'($urandom_range(0, 1)),
                            SDA_RAND, 1'b0);
            end
        end
        run_command(CMD_STOP, 8'($urandom), 1'b0, SDA_RAND, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin
        int round_ticks;
        int round_limit;

        // A start at the reset setting of phase_ticks. Its first phase is
        // still held when the setting is lowered, so it then ends at once
        // and the rest of the start runs with single-tick phases.
        push_tick(1'b1, CMD_START, 8'h00, 1'b0, SDA_RAND);
        push_idle(20, SDA_RAND, 1'b0);

        // Every command but the start, each at least once, with single-tick phases,
        // including the byte and SDA extremes.
        push_cfg(16'd1);
        push_idle(4, SDA_RAND, 1'b0);
        run_command(CMD_TX_BYTE, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_command(CMD_RX_ACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_command(CMD_TX_BYTE, 8'hFF, 1'b1, SDA_RAND, 1'b0);
        run_command(CMD_TX_ACK, 8'hFF, 1'b0, SDA_RAND, 1'b0);
        run_command(CMD_RX_BYTE, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_command(CMD_TX_ACK, 8'h00, 1'b1, SDA_RAND, 1'b0);
        run_command(CMD_RX_BYTE, 8'hFF, 1'b1, SDA_LOW, 1'b0);
        run_command(CMD_RX_ACK, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_command(CMD_TX_BYTE, 8'hA5, 1'b0, SDA_RAND, 1'b0);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

        // Spare mode codes offered while idle must start nothing.
        run_command(MODE_SPARE_LO, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_command(MODE_SPARE_HI, 8'hFF, 1'b1, SDA_RAND, 1'b0);

        // A command offered while a byte is being sent is dropped.
        push_tick(1'b1, CMD_TX_BYTE, 8'h5A, 1'b0, SDA_RAND);
        push_tick(1'b1, CMD_STOP, 8'h00, 1'b0, SDA_RAND);
        push_idle(24, SDA_RAND, 1'b0);

        // A command offered on the tick that done is raised is dropped too,
        // and one offered on the tick after is taken.
        push_tick(1'b1, CMD_START, 8'h00, 1'b0, SDA_RAND);
        push_idle(2, SDA_RAND, 1'b0);
        push_tick(1'b1, CMD_STOP, 8'h00, 1'b0, SDA_RAND);
        run_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b0);

        // A zero setting behaves as one.
        push_cfg(16'd0);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_command(CMD_RX_BYTE, 8'h00, 1'b0, SDA_RAND, 1'b0);

        // The largest setting, lowered while a phase is running: the held
        // phase then ends at once.
        push_cfg(16'hFFFF);
        push_tick(1'b1, CMD_START, 8'h00, 1'b0, SDA_RAND);
        push_idle(200, SDA_RAND, 1'b0);
        push_cfg(16'd3);
        push_idle(16, SDA_RAND, 1'b0);
        push_cfg(16'd2);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

        // Random part: mostly well-formed transfers with random content,
        // some broken or stray commands, at a few settings. Each round
        // stops once it has queued its share of tick words.
        for (int round = 0; round < 3; round++) begin
            round_ticks = (round == 0) ? 1 : (round == 1) ? $urandom_range(2, 5) : 0;
            push_cfg(16'(round_ticks));
            cmds_issued = 0;
            round_limit = words_queued + 440;
            while (cmds_issued < 600 && words_queued < round_limit) begin
                if ($urandom_range(0, 5) != 0)
                    run_transfer();
                else
                    repeat ($urandom_range(1, 4))
                        run_command(3'($urandom_range(0, 7)), 8'($urandom),
                                    1'($urandom_range(0, 1)), SDA_RAND,
                                    $urandom_range(0, 1) == 1);
            end
        end

        stimulus_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: works through the pending queue in bursts with random gaps.
    // phase_ticks is only written once every expected word has arrived.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_words
        logic     valid_next;
        logic     we_next;
        t_pending head;

        valid_next = s_axis_tvalid;
        we_next    = 1'b0;
        if (word_taken) begin
            word_taken = 1'b0;
            valid_next = 1'b0;
        end

        if (i_rst_n && !valid_next) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > 0) begin
                head = pending_words[0];
                if (head.is_cfg) begin
                    if (expected_levels.size() == 0) begin
                        we_next     = 1'b1;
                        i_cfg_wdata <= head.cfg_value;
                        hold_ticks  = head.cfg_value;
                        void'(pending_words.pop_front());
                    end
                end else begin
                    cur_tick     = head.tick;
                    s_axis_tdata <= {6'd0, head.tick.sda_in, head.tick.ack_level,
                                     head.tick.tx_byte};
                    s_axis_tuser <= {head.tick.mode, head.tick.cmd_valid};
                    valid_next   = 1'b1;
                    void'(pending_words.pop_front());
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end

        s_axis_tvalid <= valid_next;
        i_cfg_we      <= we_next;
    end

    // The result side stalls in stretches: always ready, light random
    // stalls, a fixed duty pattern, or mostly stalled.
    always @(negedge i_clk) begin : pace_results
        cycle_count++;
        if (cycle_count % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ((cycle_count % 7) < 3);
            default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor and predictor hook, both at the rising edge. A result word is
    // checked against the oldest expectation; an accepted tick word is fed
    // to the predictor. A word's result never comes back on the edge that
    // takes it, so the order within this block is safe.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_words
        t_result got;
        t_result want;

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.scl_out  = m_axis_tdata[0];
            got.sda_out  = m_axis_tdata[1];
            got.busy_res = m_axis_tdata[2];
            got.done_res = m_axis_tdata[3];
            got.rx_byte  = m_axis_tdata[11:4];
            got.ack_seen = m_axis_tdata[12];
            if (expected_levels.size() == 0) begin
                $error("result word %0h arrived with no expectation waiting", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_levels.pop_front();
                check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
                check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
            end
        end

        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_levels.push_back(step_engine(cur_tick));
            word_taken = 1'b1;
            words_taken++;
        end
    end

    // ------------------------------------------------------------------
    // End of run: all words taken, all results back, then a short settle
    // so that any stray result word is caught.
    // ------------------------------------------------------------------
    initial begin
        while (!(stimulus_done && words_taken == words_queued &&
                 expected_levels.size() == 0))
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_levels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
